// ===== src/gbi_pkg.sv =====
package gbi_pkg;

    localparam int DEF_POSITION_BITS       = 24;
    localparam int DEF_ANGLE_FRACTION_BITS = 16;
    localparam int DEF_MAX_BEAMS_PER_AXIS  = 16;

    localparam int CORDIC_STEPS = 24;
    localparam int TABLE_BITS   = 24;
    localparam int GUARD_BITS   = 8;
    localparam int KINV_BITS    = 20;
    localparam int KINV_Q20     = 636751;

    localparam int COUNT_BITS     = 5;
    localparam int SLOT_BITS      = 4;
    localparam int BEAM_BITS      = 8;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_X           = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_Y           = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_Z           = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BEAMS_HORIZONTAL = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BEAMS_VERTICAL   = 3'd4;

    localparam int BASE_Z_RESET = 6400;
    localparam int BEAMS_RESET  = 8;

    // atan(2^-i)/pi in Q.24
    localparam int ATAN_Q24 [CORDIC_STEPS] = '{
        4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } gbi_ctrl_t;

    function automatic int step_angle(input int i, input int frac_bits);
        int sh;
        int t;
        sh = TABLE_BITS - frac_bits;
        t  = ATAN_Q24[i];
        if (sh == 0)
        begin
            return t;
        end
        return (t + (1 << (sh - 1))) >> sh;
    endfunction

endpackage

// ===== src/gbi_cordic_step.sv =====
module gbi_cordic_step #(
    parameter int STEP = 0,
    parameter int W    = 35,
    parameter int A    = 19,
    parameter int F    = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gbi_pkg::gbi_ctrl_t       ctrl_in,
    input  logic signed [W-1:0]      x_in,
    input  logic signed [W-1:0]      y_in,
    input  logic signed [A-1:0]      z_in,
    output gbi_pkg::gbi_ctrl_t       ctrl_out,
    output logic signed [W-1:0]      x_out,
    output logic signed [W-1:0]      y_out,
    output logic signed [A-1:0]      z_out
);
    import gbi_pkg::*;

    localparam logic signed [A-1:0] STEP_ANGLE = A'(step_angle(STEP, F));

    gbi_ctrl_t           ctrl_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic signed [A-1:0] z_reg, z_next;

    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

// ===== src/gbi_cordic.sv =====
module gbi_cordic #(
    parameter int W = 35,
    parameter int A = 19,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    output logic                out_valid,
    output logic signed [W-1:0] out_mag,
    output logic signed [A-1:0] out_angle
);
    import gbi_pkg::*;

    localparam logic signed [A-1:0] HALF_TURN = A'(1) << F;

    gbi_ctrl_t           ctrl0_reg, ctrl0_next;
    logic signed [W-1:0] x0_reg, x0_next;
    logic signed [W-1:0] y0_reg, y0_next;
    logic signed [A-1:0] z0_reg, z0_next;

    gbi_ctrl_t           ctrl_s [CORDIC_STEPS+1];
    logic signed [W-1:0] x_s    [CORDIC_STEPS+1];
    logic signed [W-1:0] y_s    [CORDIC_STEPS+1];
    logic signed [A-1:0] z_s    [CORDIC_STEPS+1];

    // left half plane folds over by a half turn
    always_comb
    begin
        ctrl0_next.valid = in_valid;
        ctrl0_next.zero  = (in_x == '0) && (in_y == '0);
        if (in_x[W-1])
        begin
            x0_next = -in_x;
            y0_next = -in_y;
            z0_next = in_y[W-1] ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            x0_next = in_x;
            y0_next = in_y;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg <= '0;
        end
        else
        begin
            ctrl0_reg <= ctrl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        z0_reg <= z0_next;
    end

    assign ctrl_s[0] = ctrl0_reg;
    assign x_s[0]    = x0_reg;
    assign y_s[0]    = y0_reg;
    assign z_s[0]    = z0_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        gbi_cordic_step #(
            .STEP (k),
            .W    (W),
            .A    (A),
            .F    (F)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[k]),
            .x_in     (x_s[k]),
            .y_in     (y_s[k]),
            .z_in     (z_s[k]),
            .ctrl_out (ctrl_s[k+1]),
            .x_out    (x_s[k+1]),
            .y_out    (y_s[k+1]),
            .z_out    (z_s[k+1])
        );
    end

    assign out_valid = ctrl_s[CORDIC_STEPS].valid;
    assign out_mag   = x_s[CORDIC_STEPS];
    assign out_angle = ctrl_s[CORDIC_STEPS].zero ? '0 : z_s[CORDIC_STEPS];

endmodule

// ===== src/gbi_slot_map.sv =====
module gbi_slot_map #(
    parameter int A   = 19,
    parameter int F   = 16,
    parameter int MAX = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [A-1:0]                   azimuth,
    input  logic signed [A-1:0]                   elevation,
    input  logic [gbi_pkg::COUNT_BITS-1:0]        beams_h,
    input  logic [gbi_pkg::COUNT_BITS-1:0]        beams_v,
    output logic                                  out_valid,
    output logic [gbi_pkg::BEAM_BITS-1:0]         beam_number,
    output logic [gbi_pkg::SLOT_BITS-1:0]         azimuth_slot,
    output logic [gbi_pkg::SLOT_BITS-1:0]         elevation_slot
);
    import gbi_pkg::*;

    localparam int NBW = $clog2(MAX + 1);
    localparam int SW  = 2 * NBW + 1;

    localparam logic signed [A:0] AZ_OFFSET = (A+1)'(1) << (F - 1);
    localparam logic signed [A:0] AZ_FULL   = (A+1)'(1) << F;
    localparam logic signed [A:0] EL_OFFSET = (A+1)'(1) << (F - 2);
    localparam logic signed [A:0] EL_FULL   = (A+1)'(1) << (F - 1);

    function automatic logic [NBW-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
        if (c == '0)
        begin
            return NBW'(1);
        end
        if (int'(c) > MAX)
        begin
            return NBW'(MAX);
        end
        return NBW'(c);
    endfunction

    logic signed [A:0] az_sum, el_sum;
    logic [NBW-1:0]    nh, nv;

    logic              s1_valid_reg;
    logic [F:0]        an_reg, an_next;
    logic [F-1:0]      en_reg, en_next;
    logic [NBW-1:0]    nhm1_reg, nvm1_reg, nv1_reg;

    logic              s2_valid_reg;
    logic [F+NBW:0]    hprod;
    logic [F+NBW-1:0]  vprod;
    logic [NBW-1:0]    h_reg, v_reg, nv2_reg;

    logic [SW-1:0]     beam_sum;
    logic              s3_valid_reg;
    logic [BEAM_BITS-1:0] beam_reg;
    logic [SLOT_BITS-1:0] az_slot_reg, el_slot_reg;

    assign az_sum = {azimuth[A-1], azimuth} + AZ_OFFSET;
    assign el_sum = {elevation[A-1], elevation} + EL_OFFSET;
    assign nh     = clamp_count(beams_h);
    assign nv     = clamp_count(beams_v);

    always_comb
    begin
        if (az_sum[A])
        begin
            an_next = '0;
        end
        else if (az_sum > AZ_FULL)
        begin
            an_next = AZ_FULL[F:0];
        end
        else
        begin
            an_next = az_sum[F:0];
        end

        if (el_sum[A])
        begin
            en_next = '0;
        end
        else if (el_sum > EL_FULL)
        begin
            en_next = EL_FULL[F-1:0];
        end
        else
        begin
            en_next = el_sum[F-1:0];
        end
    end

    assign hprod    = (F+NBW+1)'(an_reg) * (F+NBW+1)'(nhm1_reg);
    assign vprod    = (F+NBW)'(en_reg) * (F+NBW)'(nvm1_reg);
    assign beam_sum = SW'(h_reg) * SW'(nv2_reg) + SW'(v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg      <= an_next;
        en_reg      <= en_next;
        nhm1_reg    <= nh - NBW'(1);
        nvm1_reg    <= nv - NBW'(1);
        nv1_reg     <= nv;

        h_reg       <= hprod[F +: NBW];
        v_reg       <= vprod[F-1 +: NBW];
        nv2_reg     <= nv1_reg;

        beam_reg    <= BEAM_BITS'(beam_sum);
        az_slot_reg <= SLOT_BITS'(h_reg);
        el_slot_reg <= SLOT_BITS'(v_reg);
    end

    assign out_valid      = s3_valid_reg;
    assign beam_number    = beam_reg;
    assign azimuth_slot   = az_slot_reg;
    assign elevation_slot = el_slot_reg;

endmodule

// ===== src/geometric_beam_index_unit.sv =====
// Picks one beam of a horizontal-by-vertical grid from the direction of a terminal
// seen from the configured base station. One item is taken every clock cycle and busy
// never rises. A result appears on the output ports, marked by done for a single
// cycle; the receiver cannot stall, so it must take done whenever it comes. Each item
// passes the offset register, two 24-step CORDIC vectoring pipelines (a pre-rotation
// stage, then one rotation step per register stage), the gain correction multiply and
// the three-stage slot mapping. Configuration is written through cfg_valid/cfg_ready
// (always ready); the user must write it only while no item is in flight, which the
// block itself does not enforce. Unknown indexes are ignored.
module geometric_beam_index_unit #(
    parameter int POSITION_BITS       = gbi_pkg::DEF_POSITION_BITS,
    parameter int ANGLE_FRACTION_BITS = gbi_pkg::DEF_ANGLE_FRACTION_BITS,
    parameter int MAX_BEAMS_PER_AXIS  = gbi_pkg::DEF_MAX_BEAMS_PER_AXIS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [POSITION_BITS-1:0]       term_x,
    input  logic signed [POSITION_BITS-1:0]       term_y,
    input  logic signed [POSITION_BITS-1:0]       term_z,
    output logic                                  done,
    output logic [gbi_pkg::BEAM_BITS-1:0]         beam_number,
    output logic [gbi_pkg::SLOT_BITS-1:0]         azimuth_slot,
    output logic [gbi_pkg::SLOT_BITS-1:0]         elevation_slot,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gbi_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [POSITION_BITS-1:0]              cfg_data
);
    import gbi_pkg::*;

    localparam int P     = POSITION_BITS;
    localparam int F     = ANGLE_FRACTION_BITS;
    localparam int W     = P + GUARD_BITS + 3;
    localparam int A     = F + 3;
    localparam int MW    = W - 1;
    localparam int PW    = MW + KINV_BITS;
    localparam int DEPTH = CORDIC_STEPS + 3;

    localparam logic [KINV_BITS-1:0] KINV  = KINV_BITS'(KINV_Q20);
    localparam logic [PW:0]          ROUND = (PW+1)'(1) << (KINV_BITS - 1);

    logic                    accept;

    logic [P-1:0]            base_x_reg, base_y_reg, base_z_reg;
    logic [COUNT_BITS-1:0]   beams_h_reg, beams_v_reg;

    logic signed [P:0]       diff_x, diff_y, diff_z;
    logic                    d_valid_reg;
    logic signed [W-1:0]     dx_reg, dy_reg, dz_reg;

    logic                    az_valid;
    logic signed [W-1:0]     az_mag;
    logic signed [A-1:0]     az_angle;

    logic                    p_valid_reg;
    logic [PW-1:0]           prod_reg;
    logic [PW:0]             prod_round;
    logic                    h_valid_reg;
    logic signed [W-1:0]     hor_reg;

    logic signed [W-1:0]     dz_line_reg [DEPTH];
    logic signed [A-1:0]     az_line_reg [DEPTH];

    logic                    el_valid;
    logic signed [W-1:0]     el_mag;
    logic signed [A-1:0]     el_angle;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg  <= '0;
            base_y_reg  <= '0;
            base_z_reg  <= P'(BASE_Z_RESET);
            beams_h_reg <= COUNT_BITS'(BEAMS_RESET);
            beams_v_reg <= COUNT_BITS'(BEAMS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_X:           base_x_reg  <= cfg_data;
                CFG_BASE_Y:           base_y_reg  <= cfg_data;
                CFG_BASE_Z:           base_z_reg  <= cfg_data;
                CFG_BEAMS_HORIZONTAL: beams_h_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_BEAMS_VERTICAL:   beams_v_reg <= cfg_data[COUNT_BITS-1:0];
                default:              ;
            endcase
        end
    end

    assign diff_x = {term_x[P-1], term_x} - {base_x_reg[P-1], base_x_reg};
    assign diff_y = {term_y[P-1], term_y} - {base_y_reg[P-1], base_y_reg};
    assign diff_z = {term_z[P-1], term_z} - {base_z_reg[P-1], base_z_reg};

    // offsets get guard bits below the point
    always_ff @(posedge clk)
    begin
        dx_reg <= W'(signed'({diff_x, {GUARD_BITS{1'b0}}}));
        dy_reg <= W'(signed'({diff_y, {GUARD_BITS{1'b0}}}));
        dz_reg <= W'(signed'({diff_z, {GUARD_BITS{1'b0}}}));
    end

    gbi_cordic #(
        .W (W),
        .A (A),
        .F (F)
    ) u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_x      (dx_reg),
        .in_y      (dy_reg),
        .out_valid (az_valid),
        .out_mag   (az_mag),
        .out_angle (az_angle)
    );

    // remove cordic gain, rounded
    assign prod_round = {1'b0, prod_reg} + ROUND;

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(az_mag[MW-1:0]) * PW'(KINV);
        hor_reg  <= signed'({1'b0, prod_round[KINV_BITS +: MW]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= accept;
            p_valid_reg <= az_valid;
            h_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_line_reg[0] <= dz_reg;
        az_line_reg[0] <= az_angle;
        for (int k = 1; k < DEPTH; k++)
        begin
            dz_line_reg[k] <= dz_line_reg[k-1];
            az_line_reg[k] <= az_line_reg[k-1];
        end
    end

    gbi_cordic #(
        .W (W),
        .A (A),
        .F (F)
    ) u_cordic_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_valid_reg),
        .in_x      (hor_reg),
        .in_y      (dz_line_reg[DEPTH-1]),
        .out_valid (el_valid),
        .out_mag   (el_mag),
        .out_angle (el_angle)
    );

    gbi_slot_map #(
        .A   (A),
        .F   (F),
        .MAX (MAX_BEAMS_PER_AXIS)
    ) u_slot_map (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (el_valid && (el_mag >= 0 || el_mag < 0)),
        .azimuth        (az_line_reg[DEPTH-1]),
        .elevation      (el_angle),
        .beams_h        (beams_h_reg),
        .beams_v        (beams_v_reg),
        .out_valid      (done),
        .beam_number    (beam_number),
        .azimuth_slot   (azimuth_slot),
        .elevation_slot (elevation_slot)
    );

endmodule
